/* sv/btm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types of the binary template match marker.
package btm_pkg;

   localparam int PAT_ROWS_DEF  = 4;
   localparam int PAT_COLS_DEF  = 3;
   localparam int MAX_WIDTH_DEF = 256;

   localparam int CFG_W = 12;

   localparam logic [11:0] PATTERN_RESET = 12'd2746;
   localparam logic [7:0]  WIDTH_RESET   = 8'd20;
   localparam logic [7:0]  HEIGHT_RESET  = 8'd25;

   typedef enum logic [1:0] {
      CSR_PATTERN = 2'd0,
      CSR_WIDTH   = 2'd1,
      CSR_HEIGHT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PIX_BG   = 2'd0,
      PIX_FG   = 2'd1,
      PIX_MARK = 2'd2
   } pixel_code_type;

endpackage

/* sv/btm_cell.sv */
`timescale 1ns / 1ps
// One window column cell: pixel and match-end bits of one column, shifted to its neighbor.
module btm_cell #(
   parameter int ROWS = 4
) (
   input  logic            clock,
   input  logic            shift_en,
   input  logic [ROWS-1:0] pix_in,
   input  logic [ROWS-1:0] mark_in,
   output logic [ROWS-1:0] pix_out,
   output logic [ROWS-1:0] mark_out
);

   logic [ROWS-1:0] pix_ff;
   logic [ROWS-1:0] mark_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pix_ff  <= pix_in;
         mark_ff <= mark_in;
      end
   end

   assign pix_out  = pix_ff;
   assign mark_out = mark_ff;

endmodule

/* sv/btm_line_buf.sv */
`timescale 1ns / 1ps
// Column line buffer: one word per column, registered read with write bypass.
module btm_line_buf #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         // same column written and read: take the fresh word
         rd_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

/* sv/binary_template_match_marker.sv */
`timescale 1ns / 1ps
// Top level of the binary template match marker.
//
// Binary pixels arrive in raster order, one per req transfer. Every PAT_ROWS by
// PAT_COLS window of the frame is compared exactly against pattern_ff (bit
// r*PAT_COLS+c is window row r, column c); each transfer gets one rsp transfer
// telling whether the window ending at that pixel matched, with its top-left
// position. The same rsp also carries a delayed copy of the frame, lagging the
// input by (PAT_ROWS-1)*frame_width + PAT_COLS-1 pixels, in which foreground
// pixels covered by any matching window read 2. After the last pixel, drain
// transfers flush the remaining delayed pixels. Frames smaller than the pattern
// never match and pass through undelayed. Throughput is one pixel per clock
// unless rsp stalls: a line buffer with a registered read, prefetched one
// column ahead, feeds a row of PAT_COLS column cells that hold the window, and
// the rsp register lets a new pixel be taken in the same cycle a waiting result
// is taken. rsp_valid rises in the cycle after a req transfer. No clearing pass
// after reset: buffer contents from before the current frame are never used.
module binary_template_match_marker
   import btm_pkg::*;
#(
   parameter int PAT_ROWS  = PAT_ROWS_DEF,
   parameter int PAT_COLS  = PAT_COLS_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_pixel,
   input  logic             req_start_of_frame,
   input  logic             req_drain,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_match_found,
   output logic [7:0]       rsp_match_row,
   output logic [7:0]       rsp_match_col,
   output logic             rsp_out_valid,
   output logic [1:0]       rsp_out_pixel,
   output logic [7:0]       rsp_out_row,
   output logic [7:0]       rsp_out_col,
   output logic             rsp_out_last,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int NB = PAT_ROWS * PAT_COLS;
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [11:0] PAT_MASK = (NB >= 12) ? 12'hFFF : 12'((1 << NB) - 1);

   // configuration
   logic [11:0] pattern_ff;
   logic [7:0]  width_ff;
   logic [7:0]  height_ff;

   // position and count state
   logic [8:0]  in_row_ff,  in_row_in;
   logic [7:0]  in_col_ff,  in_col_in;
   logic [8:0]  out_row_ff, out_row_in;
   logic [7:0]  out_col_ff, out_col_in;
   logic [15:0] in_cnt_ff,  in_cnt_in;
   logic [15:0] out_cnt_ff, out_cnt_in;

   // result register
   logic        rsp_valid_ff;
   logic        match_found_ff, match_found_in;
   logic [7:0]  match_row_ff,   match_row_in;
   logic [7:0]  match_col_ff,   match_col_in;
   logic        out_valid_ff,   out_valid_in;
   logic [1:0]  out_pixel_ff,   out_pixel_in;
   logic [7:0]  out_row_res_ff, out_row_res_in;
   logic [7:0]  out_col_res_ff, out_col_res_in;
   logic        out_last_ff,    out_last_in;

   logic        accept;
   logic [15:0] total;
   logic        fits;
   logic [16:0] lag;
   logic [8:0]  row0, orow0;
   logic [7:0]  col0, ocol0;
   logic [15:0] ic0, oc0;
   logic        real_px;
   logic [16:0] ic1, diff;
   logic        emit;
   logic        shift;
   logic [8:0]  col_p1, ocol_p1;
   logic        wrap, owrap;
   logic [7:0]  col_nxt;
   logic [8:0]  row_nxt;
   logic        px_eff;
   logic        test;
   logic        match;
   logic        mark_any;
   logic [8:0]  top9;
   logic [7:0]  left8;
   logic [16:0] oc_p1;

   logic [PAT_ROWS-1:0]   old_pix, old_mark, new_pix, new_mark;
   logic [2*PAT_ROWS-1:0] lb_rd, lb_wr;
   logic [PAT_ROWS-1:0]   slot_pix_q  [PAT_COLS];
   logic [PAT_ROWS-1:0]   slot_mark_q [PAT_COLS];
   logic [PAT_ROWS-1:0]   slot_pix_d  [PAT_COLS];
   logic [PAT_ROWS-1:0]   slot_mark_d [PAT_COLS];
   logic [NB-1:0]         win;
   logic [NB-1:0]         pat_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // frame geometry
   assign total = width_ff * height_ff;
   assign fits  = (width_ff >= 8'(PAT_COLS)) && (height_ff >= 8'(PAT_ROWS));
   assign lag   = fits ? (17'(PAT_ROWS - 1) * {9'd0, width_ff} + 17'(PAT_COLS - 1)) : 17'd0;

   // start of frame restarts every counter for this transfer
   assign row0  = req_start_of_frame ? 9'd0  : in_row_ff;
   assign col0  = req_start_of_frame ? 8'd0  : in_col_ff;
   assign orow0 = req_start_of_frame ? 9'd0  : out_row_ff;
   assign ocol0 = req_start_of_frame ? 8'd0  : out_col_ff;
   assign ic0   = req_start_of_frame ? 16'd0 : in_cnt_ff;
   assign oc0   = req_start_of_frame ? 16'd0 : out_cnt_ff;

   assign real_px = !req_drain && (ic0 < total);
   assign ic1     = {1'b0, ic0} + {16'd0, real_px};
   assign diff    = ic1 - {1'b0, oc0};
   assign emit    = ({1'b0, oc0} < ic1) &&
                    ((diff > lag) || (req_drain && (ic1 >= {1'b0, total})));
   // a drain transfer that flushes a pixel moves the window on like a blank pixel
   assign shift   = accept && (real_px || (req_drain && emit));

   assign col_p1  = {1'b0, col0} + 9'd1;
   assign wrap    = col_p1 >= {1'b0, width_ff};
   assign col_nxt = wrap ? 8'd0 : col_p1[7:0];
   assign row_nxt = wrap ? (row0 + 9'd1) : row0;

   assign px_eff = real_px && req_pixel;

   // column vector: bit 0 is the oldest row, bit PAT_ROWS-1 the current row
   assign old_pix  = lb_rd[PAT_ROWS-1:0];
   assign old_mark = lb_rd[2*PAT_ROWS-1:PAT_ROWS];
   assign new_pix  = (old_pix >> 1) | (PAT_ROWS'(px_eff) << (PAT_ROWS - 1));
   assign new_mark = (old_mark >> 1) | (PAT_ROWS'(match) << (PAT_ROWS - 1));
   assign lb_wr    = {new_mark, new_pix};

   always_comb begin
      for (int j = 0; j < PAT_COLS; j++) begin
         if (j == PAT_COLS - 1) begin
            slot_pix_d[j]  = new_pix;
            slot_mark_d[j] = new_mark;
         end else begin
            slot_pix_d[j]  = slot_pix_q[j + 1];
            slot_mark_d[j] = slot_mark_q[j + 1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < PAT_ROWS; i++) begin
         for (int j = 0; j < PAT_COLS; j++) begin
            win[i * PAT_COLS + j] = slot_pix_d[j][i];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NB; k++) begin
         pat_wide[k] = (k < 12) ? pattern_ff[k % 12] : 1'b0;
      end
   end

   assign test  = real_px && fits && (row0 >= 9'(PAT_ROWS - 1)) && (col0 >= 8'(PAT_COLS - 1));
   assign match = test && (win == pat_wide);

   // any match ending in the window covers the pixel leaving at its top-left
   always_comb begin
      mark_any = 1'b0;
      for (int j = 0; j < PAT_COLS; j++) begin
         mark_any = mark_any | (|slot_mark_d[j]);
      end
   end

   assign top9  = row0 - 9'(PAT_ROWS - 1);
   assign left8 = col0 - 8'(PAT_COLS - 1);

   assign ocol_p1 = {1'b0, ocol0} + 9'd1;
   assign owrap   = ocol_p1 >= {1'b0, width_ff};
   assign oc_p1   = {1'b0, oc0} + 17'd1;

   always_comb begin
      in_row_in  = shift ? row_nxt : row0;
      in_col_in  = shift ? col_nxt : col0;
      in_cnt_in  = ic1[15:0];
      out_cnt_in = emit ? oc_p1[15:0] : oc0;
      out_row_in = orow0;
      out_col_in = ocol0;
      if (emit) begin
         out_col_in = owrap ? 8'd0 : ocol_p1[7:0];
         out_row_in = owrap ? (orow0 + 9'd1) : orow0;
      end
   end

   always_comb begin
      match_found_in = match;
      match_row_in   = match ? top9[7:0] : 8'd0;
      match_col_in   = match ? left8 : 8'd0;
      out_valid_in   = emit;
      out_pixel_in   = PIX_BG;
      out_row_res_in = 8'd0;
      out_col_res_in = 8'd0;
      out_last_in    = 1'b0;
      if (emit) begin
         if (fits) begin
            if (slot_pix_d[0][0]) begin
               out_pixel_in = mark_any ? PIX_MARK : PIX_FG;
            end
         end else if (px_eff) begin
            out_pixel_in = PIX_FG;
         end
         out_row_res_in = orow0[7:0];
         out_col_res_in = ocol0;
         out_last_in    = (oc_p1 == {1'b0, total});
      end
   end

   btm_line_buf #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW),
      .DW    (2 * PAT_ROWS)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (col0[AW-1:0]),
      .wr_data (lb_wr),
      .rd_en   (shift),
      .rd_addr (col_nxt[AW-1:0]),
      .rd_data (lb_rd)
   );

   for (genvar g = 0; g < PAT_COLS; g++) begin : g_cell
      btm_cell #(
         .ROWS (PAT_ROWS)
      ) u_cell (
         .clock    (clock),
         .shift_en (shift),
         .pix_in   (slot_pix_d[g]),
         .mark_in  (slot_mark_d[g]),
         .pix_out  (slot_pix_q[g]),
         .mark_out (slot_mark_q[g])
      );
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PATTERN_RESET & PAT_MASK;
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN: begin
               pattern_ff <= csr_wdata[11:0] & PAT_MASK;
            end
            CSR_WIDTH: begin
               width_ff <= csr_wdata[7:0];
            end
            CSR_HEIGHT: begin
               height_ff <= csr_wdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
      end else if (accept) begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         in_cnt_ff  <= in_cnt_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         match_found_ff <= match_found_in;
         match_row_ff   <= match_row_in;
         match_col_ff   <= match_col_in;
         out_valid_ff   <= out_valid_in;
         out_pixel_ff   <= out_pixel_in;
         out_row_res_ff <= out_row_res_in;
         out_col_res_ff <= out_col_res_in;
         out_last_ff    <= out_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = match_found_ff;
   assign rsp_match_row   = match_row_ff;
   assign rsp_match_col   = match_col_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_out_pixel   = out_pixel_ff;
   assign rsp_out_row     = out_row_res_ff;
   assign rsp_out_col     = out_col_res_ff;
   assign rsp_out_last    = out_last_ff;

endmodule

/* sv/btm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the binary template match marker, bound to the top level.
module btm_checker
   import btm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_match_found,
   input logic [7:0]       rsp_match_row,
   input logic [7:0]       rsp_match_col,
   input logic             rsp_out_valid,
   input logic [1:0]       rsp_out_pixel,
   input logic             rsp_out_last
);

   // a held result blocks new input
   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("req_ready high while result is stalled");

   // every input transfer yields a result on the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("input transfer without result");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_match_found) |-> (rsp_match_row == 8'd0 && rsp_match_col == 8'd0))
      else $error("match position without match");

   a_pixel_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_valid && rsp_out_pixel != 2'd3) ||
                     (!rsp_out_valid && rsp_out_pixel == PIX_BG && !rsp_out_last)))
      else $error("bad delayed pixel fields");

endmodule

bind binary_template_match_marker btm_checker u_btm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_match_found (rsp_match_found),
   .rsp_match_row   (rsp_match_row),
   .rsp_match_col   (rsp_match_col),
   .rsp_out_valid   (rsp_out_valid),
   .rsp_out_pixel   (rsp_out_pixel),
   .rsp_out_last    (rsp_out_last)
);
